// ===== design/ttp_pkg.sv =====
package ttp_pkg;

	localparam int POS_FRAC_BITS = 16;
	localparam int FRAC_SHIFT    = 19;
	localparam int QBITS         = 9;
	localparam int CODE_MID      = 256;
	localparam int CODE_MAX      = 511;
	localparam int DEN_MUL       = 25;
	localparam int SLOT_W        = 10;
	localparam int WORD_W        = 30;

	localparam int POS_W   = 32;
	localparam int UVC_W   = 16;
	localparam int PD_W    = POS_W + 1;
	localparam int UD_W    = UVC_W + 1;
	localparam int NP_W    = PD_W + UD_W;
	localparam int N_W     = NP_W + 1;
	localparam int DP_W    = 2 * UD_W;
	localparam int DC_W    = DP_W + 1;
	localparam int A_W     = N_W;
	localparam int D_W     = DC_W - 1;
	localparam int DEN_W   = D_W + 5 + POS_FRAC_BITS;
	localparam int XN_W    = A_W + FRAC_SHIFT;
	localparam int DS_W    = DEN_W + QBITS;
	localparam int DIV_W   = (XN_W > DS_W ? XN_W : DS_W) + 1;

	localparam int FRONT_LAT  = 4;
	localparam int LANE_LAT   = QBITS + 3;
	localparam int PIPE_DEPTH = FRONT_LAT + LANE_LAT;

	localparam logic [WORD_W-1:0] DEFAULT_WORD = {10'd281, 10'd256, 10'd256};

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [QBITS-1:0] code_t;

	typedef struct packed {
		logic [A_W-1:0] a;
		logic           neg;
	} num_t;

endpackage

// ===== design/ttp_front.sv =====
module ttp_front (
	input  logic                      clk,
	input  logic                      en,
	input  ttp_pkg::pos_t             pos [0:8],
	input  logic [31:0]               uv [0:2],
	output ttp_pkg::num_t             num [0:2],
	output logic [ttp_pkg::D_W-1:0]   dabs,
	output logic                      degen
);

	logic signed [ttp_pkg::PD_W-1:0] p1_s1 [0:2];
	logic signed [ttp_pkg::PD_W-1:0] p2_s1 [0:2];
	logic signed [ttp_pkg::UD_W-1:0] du1_s1, dv1_s1, du2_s1, dv2_s1;
	logic signed [ttp_pkg::NP_W-1:0] n1_s2 [0:2];
	logic signed [ttp_pkg::NP_W-1:0] n2_s2 [0:2];
	logic signed [ttp_pkg::DP_W-1:0] c1_s2, c2_s2;
	logic signed [ttp_pkg::N_W-1:0]  n_s3 [0:2];
	logic signed [ttp_pkg::DC_W-1:0] dc_s3;
	ttp_pkg::num_t                   num_s4 [0:2];
	logic [ttp_pkg::D_W-1:0]         dabs_s4;
	logic                            degen_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				p1_s1[k] <= ttp_pkg::PD_W'(pos[3 + k]) - ttp_pkg::PD_W'(pos[k]);
				p2_s1[k] <= ttp_pkg::PD_W'(pos[6 + k]) - ttp_pkg::PD_W'(pos[k]);
				n1_s2[k] <= p1_s1[k] * dv2_s1;
				n2_s2[k] <= p2_s1[k] * dv1_s1;
				n_s3[k]  <= ttp_pkg::N_W'(n1_s2[k]) - ttp_pkg::N_W'(n2_s2[k]);
				num_s4[k].a   <= ttp_pkg::A_W'(n_s3[k] < 0 ? -n_s3[k] : n_s3[k]);
				num_s4[k].neg <= (n_s3[k] < 0) ^ (dc_s3 < 0);
			end
			du1_s1 <= $signed({1'b0, uv[1][15:0]}) - $signed({1'b0, uv[0][15:0]});
			dv1_s1 <= $signed({1'b0, uv[1][31:16]}) - $signed({1'b0, uv[0][31:16]});
			du2_s1 <= $signed({1'b0, uv[2][15:0]}) - $signed({1'b0, uv[0][15:0]});
			dv2_s1 <= $signed({1'b0, uv[2][31:16]}) - $signed({1'b0, uv[0][31:16]});
			c1_s2  <= du1_s1 * dv2_s1;
			c2_s2  <= dv1_s1 * du2_s1;
			dc_s3  <= ttp_pkg::DC_W'(c1_s2) - ttp_pkg::DC_W'(c2_s2);
			dabs_s4  <= ttp_pkg::D_W'(dc_s3 < 0 ? -dc_s3 : dc_s3);
			degen_s4 <= (dc_s3 == '0);
		end
	end

	assign num   = num_s4;
	assign dabs  = dabs_s4;
	assign degen = degen_s4;

endmodule

// ===== design/ttp_div_lane.sv =====
module ttp_div_lane (
	input  logic                    clk,
	input  logic                    en,
	input  ttp_pkg::num_t           num,
	input  logic [ttp_pkg::D_W-1:0] dabs,
	output ttp_pkg::code_t          code
);

	localparam int DW = ttp_pkg::DIV_W;
	localparam int QB = ttp_pkg::QBITS;

	logic [DW-1:0]  x_s0, den_s0;
	logic           neg_s0;
	logic [DW-1:0]  rem_s [0:QB];
	logic [DW-1:0]  den_s [0:QB];
	logic           neg_s [0:QB];
	logic           sat_s [0:QB];
	logic [QB-1:0]  q_s   [0:QB];
	logic [DW-1:0]  shd   [1:QB];
	logic           ge    [1:QB];
	ttp_pkg::code_t code_s;
	logic [QB:0]    qq;

	always_comb begin
		for (int k = 1; k <= QB; k++) begin
			shd[k] = den_s[k-1] << (QB - k);
			ge[k]  = rem_s[k-1] >= shd[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s0   <= DW'(num.a) << ttp_pkg::FRAC_SHIFT;
			den_s0 <= (DW'(dabs) * DW'(ttp_pkg::DEN_MUL)) << ttp_pkg::POS_FRAC_BITS;
			neg_s0 <= num.neg;
			rem_s[0] <= x_s0;
			den_s[0] <= den_s0;
			neg_s[0] <= neg_s0;
			sat_s[0] <= x_s0 >= (den_s0 << QB);
			q_s[0]   <= '0;
			for (int k = 1; k <= QB; k++) begin
				rem_s[k] <= ge[k] ? rem_s[k-1] - shd[k] : rem_s[k-1];
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				sat_s[k] <= sat_s[k-1];
				q_s[k]   <= q_s[k-1] | (QB'(ge[k]) << (QB - k));
			end
			code_s <= code_next();
		end
	end

	assign qq = {1'b0, q_s[QB]} + (QB+1)'(rem_s[QB] != '0);

	function automatic ttp_pkg::code_t code_next();
		ttp_pkg::code_t c;
		if (neg_s[QB]) begin
			if (sat_s[QB] || qq > (QB+1)'(ttp_pkg::CODE_MID))
				c = '0;
			else
				c = QB'((QB+1)'(ttp_pkg::CODE_MID) - qq);
		end else begin
			if (sat_s[QB] || q_s[QB] > QB'(ttp_pkg::CODE_MAX - ttp_pkg::CODE_MID))
				c = QB'(ttp_pkg::CODE_MAX);
			else
				c = QB'(ttp_pkg::CODE_MID) + q_s[QB];
		end
		return c;
	endfunction

	assign code = code_s;

endmodule

// ===== design/triangle_tangent_pack.sv =====
// Per-triangle tangent unit. One triangle request (three Q16.16 positions and three
// packed UV words) can be taken every cycle while the output is not stalled; four
// stages form the deltas, products and determinant, then each component runs through
// its own one-bit-per-stage restoring divider (two setup stages, nine quotient stages,
// one code stage). A stall at the output holds the whole pipeline.
module triangle_tangent_pack (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [31:0]                 v0_x,
	input  logic signed [31:0]                 v0_y,
	input  logic signed [31:0]                 v0_z,
	input  logic signed [31:0]                 v1_x,
	input  logic signed [31:0]                 v1_y,
	input  logic signed [31:0]                 v1_z,
	input  logic signed [31:0]                 v2_x,
	input  logic signed [31:0]                 v2_y,
	input  logic signed [31:0]                 v2_z,
	input  logic [31:0]                        uv0_word,
	input  logic [31:0]                        uv1_word,
	input  logic [31:0]                        uv2_word,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ttp_pkg::WORD_W-1:0]         tangent_word,
	output logic                               degenerate
);

	logic                    en;
	ttp_pkg::pos_t           pos [0:8];
	logic [31:0]             uv [0:2];
	ttp_pkg::num_t           num [0:2];
	logic [ttp_pkg::D_W-1:0] dabs;
	logic                    degen;
	ttp_pkg::code_t          code [0:2];
	logic                    valid_q [0:ttp_pkg::PIPE_DEPTH-1];
	logic                    degen_q [0:ttp_pkg::LANE_LAT-1];

	assign en = !valid_q[ttp_pkg::PIPE_DEPTH-1] || out_ready;
	assign in_ready = en;

	assign pos = '{v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z};
	assign uv  = '{uv0_word, uv1_word, uv2_word};

	ttp_front u_front (
		.clk   (clk),
		.en    (en),
		.pos   (pos),
		.uv    (uv),
		.num   (num),
		.dabs  (dabs),
		.degen (degen)
	);

	for (genvar k = 0; k < 3; k++) begin : g_lane
		ttp_div_lane u_lane (
			.clk  (clk),
			.en   (en),
			.num  (num[k]),
			.dabs (dabs),
			.code (code[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ttp_pkg::PIPE_DEPTH; i++)
				valid_q[i] <= 1'b0;
		end else if (en) begin
			valid_q[0] <= in_valid;
			for (int i = 1; i < ttp_pkg::PIPE_DEPTH; i++)
				valid_q[i] <= valid_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_q[0] <= degen;
			for (int i = 1; i < ttp_pkg::LANE_LAT; i++)
				degen_q[i] <= degen_q[i-1];
		end
	end

	assign out_valid  = valid_q[ttp_pkg::PIPE_DEPTH-1];
	assign degenerate = degen_q[ttp_pkg::LANE_LAT-1];
	assign tangent_word = degenerate ? ttp_pkg::DEFAULT_WORD :
		{1'b0, code[2], 1'b0, code[1], 1'b0, code[0]};

endmodule

// ===== design/ttp_checker.sv =====
module ttp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [ttp_pkg::WORD_W-1:0] tangent_word,
	input logic                       degenerate
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tangent_word) && $stable(degenerate))
		else $error("stalled result changed");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> tangent_word == ttp_pkg::DEFAULT_WORD)
		else $error("degenerate result without default tangent");

	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !tangent_word[9] && !tangent_word[19] && !tangent_word[29])
		else $error("slot top bit set");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind triangle_tangent_pack ttp_checker u_ttp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.tangent_word (tangent_word),
	.degenerate   (degenerate)
);

// ===== sim/tb_triangle_tangent_pack.sv =====
`timescale 1ns / 100ps

module tb_triangle_tangent_pack;

	typedef struct {
		logic signed [31:0] pos[9];
		logic [31:0]        uv[3];
		bit                 drain;
	} tri_t;

	typedef struct {
		logic [ttp_pkg::WORD_W-1:0] word;
		logic                       degen;
	} tangent_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] v0_x = '0, v0_y = '0, v0_z = '0;
	logic signed [31:0] v1_x = '0, v1_y = '0, v1_z = '0;
	logic signed [31:0] v2_x = '0, v2_y = '0, v2_z = '0;
	logic [31:0] uv0_word = '0, uv1_word = '0, uv2_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ttp_pkg::WORD_W-1:0] tangent_word;
	logic degenerate;

	tri_t     pending_tris[$];
	tangent_t expected_tangents[$];
	int       sent = 0, got = 0, mismatches = 0, cycles = 0;
	int       send_gap = 0, recv_gap = 0;
	bit       calm = 1'b0;

	triangle_tangent_pack i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z), .v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
		.v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
		.uv0_word(uv0_word), .uv1_word(uv1_word), .uv2_word(uv2_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.tangent_word(tangent_word), .degenerate(degenerate)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void queue_tri(tri_t t);
		pending_tris.insert(pending_tris.size(), t);
	endfunction

	function automatic void queue_expected(tangent_t e);
		expected_tangents.insert(expected_tangents.size(), e);
	endfunction

	// floor of num*2^19/dmag with the sign of num xor dneg, offset by CODE_MID, then saturated
	function automatic logic [ttp_pkg::SLOT_W-1:0] slot_code(longint num, longint dmag,
		bit dneg);
		logic [127:0] mag, q, r;
		bit neg;
		neg = (num < 0) != dneg;
		mag = num < 0 ? -num : num;
		mag = mag << ttp_pkg::FRAC_SHIFT;
		q = mag / dmag;
		r = mag % dmag;
		if (neg) begin
			if (r != 0) q = q + 1;
			return q > ttp_pkg::CODE_MID ? '0 :
				ttp_pkg::SLOT_W'(ttp_pkg::CODE_MID - q);
		end
		return q > ttp_pkg::CODE_MAX - ttp_pkg::CODE_MID ?
			ttp_pkg::SLOT_W'(ttp_pkg::CODE_MAX) : ttp_pkg::SLOT_W'(ttp_pkg::CODE_MID + q);
	endfunction

	function automatic tangent_t tangent_of(tri_t t);
		tangent_t res;
		longint du1, dv1, du2, dv2, dc, dmag, p1, p2;
		du1 = longint'(t.uv[1][15:0]) - longint'(t.uv[0][15:0]);
		dv1 = longint'(t.uv[1][31:16]) - longint'(t.uv[0][31:16]);
		du2 = longint'(t.uv[2][15:0]) - longint'(t.uv[0][15:0]);
		dv2 = longint'(t.uv[2][31:16]) - longint'(t.uv[0][31:16]);
		dc = du1 * dv2 - dv1 * du2;
		if (dc == 0) begin
			res.word = {10'd281, 10'd256, 10'd256};
			res.degen = 1'b1;
			return res;
		end
		dmag = ((dc < 0 ? -dc : dc) * 25) << ttp_pkg::POS_FRAC_BITS;
		res.degen = 1'b0;
		for (int k = 0; k < 3; k++) begin
			p1 = longint'(t.pos[3 + k]) - longint'(t.pos[k]);
			p2 = longint'(t.pos[6 + k]) - longint'(t.pos[k]);
			res.word[ttp_pkg::SLOT_W*k +: ttp_pkg::SLOT_W] =
				slot_code(p1 * dv2 - p2 * dv1, dmag, dc < 0);
		end
		return res;
	endfunction

	function automatic logic [31:0] uv_pack(int u, int v);
		return {16'(v), 16'(u)};
	endfunction

	function automatic tri_t random_tri();
		tri_t t;
		int mode, spread, base, u0, v0;
		mode = $urandom_range(0, 9);
		spread = 1 << $urandom_range(4, 24);
		for (int k = 0; k < 3; k++) begin
			base = $urandom;
			t.pos[k] = base;
			for (int v = 1; v < 3; v++)
				t.pos[3 * v + k] = (mode < 2) ? $urandom :
					base + $signed($urandom_range(0, 2 * spread)) - spread;
		end
		u0 = $urandom_range(0, 65535);
		v0 = $urandom_range(0, 65535);
		for (int v = 0; v < 3; v++) begin
			case (mode)
				0, 2:    t.uv[v] = $urandom;
				3:       t.uv[v] = uv_pack(u0, v0 + v * 37);
				4:       t.uv[v] = uv_pack(u0 + v * 5, v0 + v * 9);
				default: t.uv[v] = uv_pack(u0 + $urandom_range(0, 2000) - 1000,
					v0 + $urandom_range(0, 2000) - 1000);
			endcase
		end
		t.drain = 1'b0;
		return t;
	endfunction

	function automatic tri_t plain_tri(int d, logic [31:0] a, logic [31:0] b,
		logic [31:0] c);
		tri_t t;
		for (int k = 0; k < 9; k++) t.pos[k] = (k >= 3 && k < 6) ? d : 0;
		for (int k = 6; k < 9; k++) t.pos[k] = -d;
		t.uv[0] = a;
		t.uv[1] = b;
		t.uv[2] = c;
		t.drain = 1'b0;
		return t;
	endfunction

	initial begin
		tri_t t;
		queue_tri(plain_tri(0, 0, 0, 0));
		queue_tri(plain_tri(65536, uv_pack(0, 0), uv_pack(1, 0), uv_pack(0, 1)));
		queue_tri(plain_tri(-65536, uv_pack(0, 0), uv_pack(0, 1), uv_pack(1, 0)));
		queue_tri(plain_tri(1, uv_pack(0, 0), uv_pack(1, 0), uv_pack(0, 1)));
		queue_tri(plain_tri(0, uv_pack(0, 0), uv_pack(65535, 0),
			uv_pack(0, 65535)));
		queue_tri(plain_tri(32'h7fffffff, uv_pack(0, 0), uv_pack(65535, 0),
			uv_pack(0, 65535)));
		queue_tri(plain_tri(32'h7fffffff, uv_pack(65535, 65535), uv_pack(0, 0),
			uv_pack(65534, 65535)));
		queue_tri(plain_tri(1000, uv_pack(100, 100), uv_pack(200, 200),
			uv_pack(300, 300)));
		queue_tri(plain_tri(3000, uv_pack(16383, 16383), uv_pack(16384, 16383),
			uv_pack(16383, 16384)));
		queue_tri(plain_tri(64000, uv_pack(8192, 8192), uv_pack(8192 + 20, 8192),
			uv_pack(8192, 8192 + 20)));
		t = plain_tri(0, uv_pack(0, 0), uv_pack(1, 0), uv_pack(0, 1));
		for (int k = 0; k < 9; k++) t.pos[k] = (k % 2) ? 32'h80000000 : 32'h7fffffff;
		queue_tri(t);
		for (int k = 0; k < 9; k++) t.pos[k] = (k % 2) ? 32'h7fffffff : 32'h80000000;
		t.uv[1] = uv_pack(0, 1);
		t.uv[2] = uv_pack(1, 0);
		queue_tri(t);
		for (int k = 0; k < 9; k++) t.pos[k] = $urandom_range(0, 1) ? 32'hffffffff : 0;
		t.uv[0] = 32'hffffffff;
		t.uv[1] = 32'h0000ffff;
		t.uv[2] = 32'hffff0000;
		queue_tri(t);
		for (int n = 0; n < 450; n++) begin
			t = random_tri();
			if (n == 200) t.drain = 1'b1;
			queue_tri(t);
		end
	end

	// request driver
	always @(posedge clk) begin
		bit take;
		tri_t t;
		take = !in_valid || in_ready;
		if (arst_n && in_valid && in_ready) sent <= sent + 1;
		calm <= pending_tris.size() < 60;
		if (!arst_n || !take) begin
		end else if (send_gap > 0) begin
			send_gap <= send_gap - 1;
			in_valid <= 1'b0;
		end else if (pending_tris.size() == 0) begin
			in_valid <= 1'b0;
		end else if (pending_tris[0].drain && (in_valid || sent != got)) begin
			in_valid <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			send_gap <= $urandom_range(1, 19) - 1;
			in_valid <= 1'b0;
		end else begin
			t = pending_tris.pop_front();
			in_valid <= 1'b1;
			{v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z} <=
				{t.pos[0], t.pos[1], t.pos[2], t.pos[3], t.pos[4], t.pos[5],
				t.pos[6], t.pos[7], t.pos[8]};
			{uv0_word, uv1_word, uv2_word} <= {t.uv[0], t.uv[1], t.uv[2]};
		end
	end

	// result monitor and output stalls
	always @(posedge clk) begin
		tri_t t;
		tangent_t want;
		cycles <= cycles + 1;
		if (arst_n && in_valid && in_ready) begin
			t.pos = '{v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z};
			t.uv = '{uv0_word, uv1_word, uv2_word};
			queue_expected(tangent_of(t));
		end
		if (arst_n && out_valid && out_ready) begin
			got <= got + 1;
			if (expected_tangents.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected result %h", tangent_word);
			end else begin
				want = expected_tangents.pop_front();
				if (want.word !== tangent_word || want.degen !== degenerate) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: expected word %h degenerate %b, got %h %b",
							want.word, want.degen, tangent_word, degenerate);
				end
			end
		end
		if (!arst_n) begin
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			recv_gap <= $urandom_range(1, 19) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_tris.size() == 0 && !in_valid);
		wait (expected_tangents.size() == 0);
		repeat (ttp_pkg::PIPE_DEPTH + 20) @(posedge clk);
		if (mismatches == 0 && expected_tangents.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (cycles > 100000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
design/ttp_pkg.sv
design/ttp_front.sv
design/ttp_div_lane.sv
design/triangle_tangent_pack.sv
design/ttp_checker.sv
sim/tb_triangle_tangent_pack.sv
